// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that one condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (conseq)) \
        else $error(msg);

`endif

// ===== sv/dth_pkg.sv =====
// ---------------------------------------------------------------------------
// dth_pkg
// Types and constants of the deadline timer heap.
// ---------------------------------------------------------------------------
package dth_pkg;

    localparam int HEAP_DEPTH = 32;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int TIME_W     = 48;
    localparam int TAG_W      = 16;
    localparam int KEY_W      = TIME_W + TAG_W;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_ARM_ABS = 2'd0,
        KIND_ARM_REL = 2'd1,
        KIND_COLLECT = 2'd2,
        KIND_WAKE    = 2'd3
    } kind_t;

    // One result word
    typedef struct packed {
        logic [TAG_W-1:0]  expired_tag;
        logic              tag_valid;
        logic              reload_request;
        logic [TIME_W-1:0] reload_deadline;
        logic              full_error;
        logic              last;
    } res_t;

endpackage

// ===== sv/dth_ram.sv =====
// ---------------------------------------------------------------------------
// dth_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module dth_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/dth_ctrl.sv =====
// ---------------------------------------------------------------------------
// dth_ctrl
// Heap sequencer: sift-up on arm, pop and sift-down on collect, reload word on wake, over one RAM.
// ---------------------------------------------------------------------------
module dth_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_kind,
    input  logic [dth_pkg::TIME_W-1:0]    in_time_value,
    input  logic [dth_pkg::TAG_W-1:0]     in_task_tag,
    input  logic [dth_pkg::TIME_W-1:0]    in_now_time,
    output logic                          res_valid,
    input  logic                          res_ready,
    output dth_pkg::res_t                 res
);

    localparam int AW = dth_pkg::ADDR_W;
    localparam int CW = dth_pkg::CNT_W;
    localparam int XW = dth_pkg::ADDR_W + 2;
    localparam int KW = dth_pkg::KEY_W;
    localparam int TW = dth_pkg::TIME_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EMIT, ST_INS_UP, ST_INS_CMP, ST_INS_TOP_RD, ST_INS_TOP,
        ST_COL_RD, ST_COL_CHK, ST_POP_LAST_RD, ST_POP_LAST, ST_POP_L,
        ST_POP_LW, ST_POP_RW, ST_POP_DEC
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [KW-1:0]      cur_reg, cur_next;
    logic [KW-1:0]      lkey_reg, lkey_next;
    logic [KW-1:0]      rkey_reg, rkey_next;
    logic               rok_reg, rok_next;
    logic [TW-1:0]      now_reg, now_next;
    dth_pkg::res_t      res_reg, res_next;

    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic [KW-1:0]      wdata, rdata;

    logic [TW:0]        rel_sum;
    logic [TW-1:0]      new_dl;
    logic [AW-1:0]      parent;
    logic [XW-1:0]      lidx, ridx, nsize;
    logic               pick_r;
    logic [KW-1:0]      child_key;
    logic [AW-1:0]      child_idx;
    dth_pkg::res_t      res_blank;

    dth_ram #(.WIDTH(KW), .DEPTH(dth_pkg::HEAP_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    // Saturating relative deadline and heap index arithmetic
    assign rel_sum   = {1'b0, in_now_time} + {1'b0, in_time_value};
    assign new_dl    = (in_kind == dth_pkg::KIND_ARM_REL)
                       ? (rel_sum[TW] ? {TW{1'b1}} : rel_sum[TW-1:0]) : in_time_value;
    assign parent    = AW'((idx_reg - AW'(1)) >> 1);
    assign lidx      = {1'b0, idx_reg, 1'b1};
    assign ridx      = lidx + XW'(1);
    assign nsize     = XW'(count_reg);
    assign pick_r    = rok_reg && (rkey_reg < lkey_reg);
    assign child_key = pick_r ? rkey_reg : lkey_reg;
    assign child_idx = pick_r ? ridx[AW-1:0] : lidx[AW-1:0];

    always_comb begin
        res_blank = '0;
    end

    // Next-state and RAM control
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        lkey_next  = lkey_reg;
        rkey_next  = rkey_reg;
        rok_next   = rok_reg;
        now_next   = now_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = cur_reg;
        re         = 1'b0;
        raddr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    now_next  = in_now_time;
                    res_next  = res_blank;
                    res_next.last = 1'b1;
                    unique case (dth_pkg::kind_t'(in_kind)) inside
                        dth_pkg::KIND_ARM_ABS, dth_pkg::KIND_ARM_REL: begin
                            if (count_reg == CW'(dth_pkg::HEAP_DEPTH)) begin
                                res_next.full_error = 1'b1;
                                ret_next   = ST_IDLE;
                                state_next = ST_EMIT;
                            end else begin
                                cur_next   = {new_dl, in_task_tag};
                                idx_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = ST_INS_UP;
                            end
                        end
                        dth_pkg::KIND_COLLECT: begin
                            state_next = ST_COL_RD;
                        end
                        default: begin
                            res_next.reload_request  = 1'b1;
                            res_next.reload_deadline = in_now_time;
                            ret_next   = ST_IDLE;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ret_reg;
                end
            end
            // Sift the hole up toward the root
            ST_INS_UP: begin
                if (idx_reg == '0) begin
                    we         = 1'b1;
                    state_next = ST_INS_TOP_RD;
                end else begin
                    re         = 1'b1;
                    raddr      = parent;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                we = 1'b1;
                if (rdata <= cur_reg) begin
                    state_next = ST_INS_TOP_RD;
                end else begin
                    wdata      = rdata;
                    idx_next   = parent;
                    state_next = ST_INS_UP;
                end
            end
            ST_INS_TOP_RD: begin
                re         = 1'b1;
                state_next = ST_INS_TOP;
            end
            ST_INS_TOP: begin
                if (rdata[KW-1 -: TW] == cur_reg[KW-1 -: TW]) begin
                    res_next.reload_request  = 1'b1;
                    res_next.reload_deadline = cur_reg[KW-1 -: TW];
                end
                ret_next   = ST_IDLE;
                state_next = ST_EMIT;
            end
            // Look at the top and pop while expired
            ST_COL_RD: begin
                if (count_reg == '0) begin
                    res_next      = res_blank;
                    res_next.last = 1'b1;
                    ret_next      = ST_IDLE;
                    state_next    = ST_EMIT;
                end else begin
                    re         = 1'b1;
                    state_next = ST_COL_CHK;
                end
            end
            ST_COL_CHK: begin
                res_next = res_blank;
                if (rdata[KW-1 -: TW] <= now_reg) begin
                    res_next.expired_tag = rdata[dth_pkg::TAG_W-1:0];
                    res_next.tag_valid   = 1'b1;
                    ret_next             = ST_POP_LAST_RD;
                end else begin
                    res_next.reload_request  = 1'b1;
                    res_next.reload_deadline = rdata[KW-1 -: TW];
                    res_next.last            = 1'b1;
                    ret_next                 = ST_IDLE;
                end
                state_next = ST_EMIT;
            end
            ST_POP_LAST_RD: begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    state_next = ST_COL_RD;
                end else begin
                    re         = 1'b1;
                    raddr      = AW'(count_reg - CW'(1));
                    state_next = ST_POP_LAST;
                end
            end
            ST_POP_LAST: begin
                cur_next   = rdata;
                idx_next   = '0;
                state_next = ST_POP_L;
            end
            // Sift the hole down from the root
            ST_POP_L: begin
                if (lidx >= nsize) begin
                    we         = 1'b1;
                    state_next = ST_COL_RD;
                end else begin
                    re         = 1'b1;
                    raddr      = lidx[AW-1:0];
                    state_next = ST_POP_LW;
                end
            end
            ST_POP_LW: begin
                lkey_next = rdata;
                rok_next  = (ridx < nsize);
                if (ridx < nsize) begin
                    re         = 1'b1;
                    raddr      = ridx[AW-1:0];
                    state_next = ST_POP_RW;
                end else begin
                    state_next = ST_POP_DEC;
                end
            end
            ST_POP_RW: begin
                rkey_next  = rdata;
                state_next = ST_POP_DEC;
            end
            ST_POP_DEC: begin
                we = 1'b1;
                if (child_key < cur_reg) begin
                    wdata      = child_key;
                    idx_next   = child_idx;
                    state_next = ST_POP_L;
                end else begin
                    state_next = ST_COL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
        end
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        lkey_reg <= lkey_next;
        rkey_reg <= rkey_next;
        rok_reg  <= rok_next;
        now_reg  <= now_next;
        res_reg  <= res_next;
    end

endmodule

// ===== sv/deadline_timer_heap.sv =====
// Sequence: an arm sifts up, through ST_INS_UP and ST_INS_CMP per heap level; a wake
//   emits one reload word; a collect pops and sinks each expired entry in turn.
// Flow: one item at a time; all heap accesses share the single read and write
//   port of the RAM.
// Reset: synchronous active-low aresetn empties the heap and drops any word.
// ---------------------------------------------------------------------------
// deadline_timer_heap
// Min-heap timer queue of (deadline, tag) entries with a registered output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module deadline_timer_heap (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // kind[1:0], time_value[49:2], task_tag[65:50], now_time[113:66]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // expired_tag[15:0], reload_deadline[63:16]
    output logic [63:0]  m_tdata,
    // tag_valid[0], reload_request[1], full_error[2]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    dth_pkg::res_t res;
    logic          res_valid, res_ready;
    logic          m_tvalid_reg;
    dth_pkg::res_t out_reg;

    dth_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tdata[1:0]),
        .in_time_value (s_tdata[49:2]),
        .in_task_tag   (s_tdata[65:50]),
        .in_now_time   (s_tdata[113:66]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    // Output register: load a new word when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.reload_deadline, out_reg.expired_tag};
    assign m_tuser  = {out_reg.full_error, out_reg.reload_request, out_reg.tag_valid};
    assign m_tlast  = out_reg.last;

    `ASSERT_IMPL(a_full_last, aclk, aresetn, m_tvalid && m_tuser[2],
                 m_tlast && !m_tuser[1], "full error word must be final, no reload")
    `ASSERT_IMPL(a_tag_not_last, aclk, aresetn, m_tvalid && m_tuser[0], !m_tlast,
                 "expired tag word must not be final")
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready,
                "input accepted while an item is in progress")

endmodule
